// File: hdl/hsv_color_threshold_mask_defines.svh
// Assertion macros for the HSV threshold mask RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef HSV_COLOR_THRESHOLD_MASK_DEFINES_SVH
`define HSV_COLOR_THRESHOLD_MASK_DEFINES_SVH

// Same-cycle implication, idle during reset
`define HSVCTM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, idle during reset
`define HSVCTM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/hsvctm_pkg.sv
// Shared constants, stage word types and register codes for the HSV threshold mask.
// No dependencies.
package hsvctm_pkg;

   localparam int unsigned ChanW     = 8;
   localparam int unsigned TabDepth  = 1 << ChanW;
   localparam int unsigned HueSpan   = 180;
   localparam int unsigned FracBits  = 12;
   localparam int unsigned RoundHalf = 1 << (FracBits - 1);
   localparam int unsigned SatNum    = 255 * (1 << FracBits);
   localparam int unsigned HueNum    = HueSpan * (1 << FracBits) / 6;
   localparam int unsigned SatRecipW = 20;
   localparam int unsigned HueRecipW = 17;
   localparam int unsigned RawW      = 12;
   localparam int unsigned SatProdW  = ChanW + SatRecipW;
   localparam int unsigned HueProdW  = RawW + HueRecipW + 1;
   localparam int unsigned HueQW     = HueProdW - FracBits;
   localparam int unsigned HsW       = ChanW + 1;
   localparam int unsigned CsrIdxW   = 3;

   localparam logic [CsrIdxW-1:0] CsrHueLow  = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrHueHigh = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrSatLow  = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrSatHigh = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrValLow  = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrValHigh = 3'd5;

   typedef struct packed {
      logic [ChanW-1:0] hue_low;
      logic [ChanW-1:0] hue_high;
      logic [ChanW-1:0] sat_low;
      logic [ChanW-1:0] sat_high;
      logic [ChanW-1:0] val_low;
      logic [ChanW-1:0] val_high;
   } bounds_type;

   // after max/min and sector selection
   typedef struct packed {
      logic [ChanW-1:0]       v;
      logic [ChanW-1:0]       diff;
      logic signed [RawW-1:0] raw;
   } s1_type;

   // after reciprocal lookup
   typedef struct packed {
      logic [ChanW-1:0]       v;
      logic [ChanW-1:0]       diff;
      logic signed [RawW-1:0] raw;
      logic [SatRecipW-1:0]   sat_recip;
      logic [HueRecipW-1:0]   hue_recip;
   } s2_type;

   // after the two multiplies
   typedef struct packed {
      logic [ChanW-1:0]           v;
      logic [SatProdW-1:0]        sat_prod;
      logic signed [HueProdW-1:0] hue_prod;
   } s3_type;

endpackage

// File: hdl/hsvctm_if.sv
// Valid/ready channel interfaces: pixel request, mask response, register write.
// Depends on hsvctm_pkg.
interface hsvctm_req_if import hsvctm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ChanW-1:0] blue;
   logic [ChanW-1:0] green;
   logic [ChanW-1:0] red;

   modport source (output valid, output blue, output green, output red, input ready);
   modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface hsvctm_rsp_if ();
   logic valid;
   logic ready;
   logic in_range;

   modport source (output valid, output in_range, input ready);
   modport sink   (input valid, input in_range, output ready);
endinterface

interface hsvctm_csr_if import hsvctm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CsrIdxW-1:0] index;
   logic [ChanW-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/hsvctm_csr.sv
// Threshold bound registers, written over the register channel.
// Depends on hsvctm_pkg, hsvctm_if and the assertion macro header.
`include "hsv_color_threshold_mask_defines.svh"

module hsvctm_csr import hsvctm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   hsvctm_csr_if.sink         csr_bus,
   output bounds_type         bounds
);

   bounds_type bounds_ff;
   bounds_type bounds_in;
   logic       wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid && csr_bus.ready;

   always_comb begin
      bounds_in = bounds_ff;
      if (wr_en) begin
         case (csr_bus.index)
            CsrHueLow:  bounds_in.hue_low  = csr_bus.data;
            CsrHueHigh: bounds_in.hue_high = csr_bus.data;
            CsrSatLow:  bounds_in.sat_low  = csr_bus.data;
            CsrSatHigh: bounds_in.sat_high = csr_bus.data;
            CsrValLow:  bounds_in.val_low  = csr_bus.data;
            CsrValHigh: bounds_in.val_high = csr_bus.data;
            default:    bounds_in = bounds_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff.hue_low  <= '0;
         bounds_ff.hue_high <= ChanW'(HueSpan);
         bounds_ff.sat_low  <= '0;
         bounds_ff.sat_high <= '1;
         bounds_ff.val_low  <= '0;
         bounds_ff.val_high <= '1;
      end else begin
         bounds_ff <= bounds_in;
      end
   end

   assign bounds = bounds_ff;

   `HSVCTM_ASSERT_NEXT(a_hue_high_write, wr_en && csr_bus.index == CsrHueHigh, bounds_ff.hue_high == $past(csr_bus.data), "hue_high write lost")
   `HSVCTM_ASSERT_NEXT(a_bad_index_ignored, wr_en && csr_bus.index != CsrHueLow && csr_bus.index != CsrHueHigh && csr_bus.index != CsrSatLow && csr_bus.index != CsrSatHigh && csr_bus.index != CsrValLow && csr_bus.index != CsrValHigh, $stable(bounds_ff), "write to unknown index changed a bound")

endmodule

// File: hdl/hsvctm_front.sv
// Front pipeline: channel max/min and hue sector, then reciprocal table lookup.
// Depends on hsvctm_pkg, hsvctm_if and the assertion macro header.
`include "hsv_color_threshold_mask_defines.svh"

module hsvctm_front import hsvctm_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   hsvctm_req_if.sink req_bus,
   output logic   s2_valid,
   output s2_type s2_word,
   input  logic   s2_take
);

   logic             s1_valid_ff;
   s1_type           s1_ff;
   s1_type           s1_in;
   logic             s2_valid_ff;
   s2_type           s2_ff;
   s2_type           s2_in;
   logic             s1_adv;
   logic             s2_adv;

   logic [ChanW-1:0]       ch_max;
   logic [ChanW-1:0]       ch_min;
   logic [ChanW-1:0]       ch_diff;
   logic signed [RawW-1:0] b_s;
   logic signed [RawW-1:0] g_s;
   logic signed [RawW-1:0] r_s;
   logic signed [RawW-1:0] d_s;

   logic [SatRecipW-1:0] sat_tab [TabDepth];
   logic [HueRecipW-1:0] hue_tab [TabDepth];

   // rounded reciprocals, zero for a zero divisor
   for (genvar i = 0; i < TabDepth; i++) begin : g_recip
      localparam int unsigned SatR = (i == 0) ? 0 :
         (2 * SatNum + i) / (2 * i + ((i == 0) ? 1 : 0));
      localparam int unsigned HueR = (i == 0) ? 0 :
         (2 * HueNum + i) / (2 * i + ((i == 0) ? 1 : 0));
      assign sat_tab[i] = SatR[SatRecipW-1:0];
      assign hue_tab[i] = HueR[HueRecipW-1:0];
   end

   assign s2_adv        = !s2_valid_ff || s2_take;
   assign s1_adv        = !s1_valid_ff || s2_adv;
   assign req_bus.ready = s1_adv;

   always_comb begin
      ch_max = req_bus.blue;
      if (req_bus.green > ch_max) ch_max = req_bus.green;
      if (req_bus.red > ch_max)   ch_max = req_bus.red;
      ch_min = req_bus.blue;
      if (req_bus.green < ch_min) ch_min = req_bus.green;
      if (req_bus.red < ch_min)   ch_min = req_bus.red;
      ch_diff = ch_max - ch_min;

      b_s = $signed(RawW'(req_bus.blue));
      g_s = $signed(RawW'(req_bus.green));
      r_s = $signed(RawW'(req_bus.red));
      d_s = $signed(RawW'(ch_diff));

      s1_in.v    = ch_max;
      s1_in.diff = ch_diff;
      // red wins ties over green, green over blue
      if (ch_max == req_bus.red) begin
         s1_in.raw = g_s - b_s;
      end else if (ch_max == req_bus.green) begin
         s1_in.raw = b_s - r_s + (d_s <<< 1);
      end else begin
         s1_in.raw = r_s - g_s + (d_s <<< 2);
      end
   end

   always_comb begin
      s2_in.v         = s1_ff.v;
      s2_in.diff      = s1_ff.diff;
      s2_in.raw       = s1_ff.raw;
      s2_in.sat_recip = sat_tab[s1_ff.v];
      s2_in.hue_recip = hue_tab[s1_ff.diff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= req_bus.valid;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && req_bus.valid) s1_ff <= s1_in;
      if (s2_adv && s1_valid_ff)   s2_ff <= s2_in;
   end

   assign s2_valid = s2_valid_ff;
   assign s2_word  = s2_ff;

   `HSVCTM_ASSERT_NOW(a_diff_below_max, s1_valid_ff, s1_ff.diff <= s1_ff.v, "range exceeds maximum channel")
   `HSVCTM_ASSERT_NEXT(a_s2_holds, s2_valid_ff && !s2_take, s2_valid_ff && $stable(s2_ff), "stalled lookup word changed")

endmodule

// File: hdl/hsvctm_back.sv
// Back pipeline: the two multiplies, then descale, hue wrap and range test into the
// output register. Depends on hsvctm_pkg, hsvctm_if and the assertion macro header.
`include "hsv_color_threshold_mask_defines.svh"

module hsvctm_back import hsvctm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       s2_valid,
   input  s2_type     s2_word,
   output logic       s2_take,
   input  bounds_type bounds,
   hsvctm_rsp_if.source rsp_bus
);

   logic   s3_valid_ff;
   s3_type s3_ff;
   s3_type s3_in;
   logic   out_valid_ff;
   logic   in_range_ff;
   logic   in_range_in;
   logic   s3_adv;
   logic   out_adv;

   logic [SatProdW:0]          sat_sum;
   logic [HsW-1:0]             sat_val;
   logic signed [HueProdW-1:0] hue_sum;
   logic signed [HueQW-1:0]    hue_q;
   logic signed [HueQW-1:0]    hue_fix;
   logic [HsW-1:0]             hue_val;
   logic                       hue_ok;
   logic                       sat_ok;
   logic                       val_ok;

   assign out_adv = !out_valid_ff || rsp_bus.ready;
   assign s3_adv  = !s3_valid_ff || out_adv;
   assign s2_take = s3_adv;

   always_comb begin
      s3_in.v        = s2_word.v;
      s3_in.sat_prod = SatProdW'(s2_word.diff) * SatProdW'(s2_word.sat_recip);
      s3_in.hue_prod = HueProdW'(s2_word.raw) *
                       $signed(HueProdW'(s2_word.hue_recip));
   end

   always_comb begin
      sat_sum = {1'b0, s3_ff.sat_prod} + (SatProdW + 1)'(RoundHalf);
      sat_val = sat_sum[FracBits +: HsW];
      // arithmetic shift floors toward minus infinity
      hue_sum = s3_ff.hue_prod + $signed(HueProdW'(RoundHalf));
      hue_q   = hue_sum[HueProdW-1:FracBits];
      hue_fix = (hue_q < 0) ? hue_q + $signed(HueQW'(HueSpan)) : hue_q;
      hue_val = hue_fix[HsW-1:0];

      if (bounds.hue_low <= bounds.hue_high) begin
         hue_ok = hue_val >= HsW'(bounds.hue_low) && hue_val <= HsW'(bounds.hue_high);
      end else begin
         // wrapped range passes through zero
         hue_ok = (hue_val >= HsW'(bounds.hue_low) && hue_val <= HsW'(HueSpan)) ||
                  hue_val <= HsW'(bounds.hue_high);
      end
      sat_ok = sat_val >= HsW'(bounds.sat_low) && sat_val <= HsW'(bounds.sat_high);
      val_ok = s3_ff.v >= bounds.val_low && s3_ff.v <= bounds.val_high;
      in_range_in = hue_ok && sat_ok && val_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s3_adv)  s3_valid_ff  <= s2_valid;
         if (out_adv) out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_adv && s2_valid)     s3_ff       <= s3_in;
      if (out_adv && s3_valid_ff) in_range_ff <= in_range_in;
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.in_range = in_range_ff;

   `HSVCTM_ASSERT_NOW(a_hue_in_span, s3_valid_ff, hue_fix >= 0 && hue_fix < $signed(HueQW'(HueSpan)), "hue outside 0 to 179")
   `HSVCTM_ASSERT_NEXT(a_s3_holds, s3_valid_ff && !s3_adv, s3_valid_ff && $stable(s3_ff), "stalled product word changed")

endmodule

// File: hdl/hsv_color_threshold_mask.sv
// Top level of the HSV color threshold mask: BGR pixel in, one mask bit out.
// Depends on hsvctm_pkg, hsvctm_if, hsvctm_csr, hsvctm_front and hsvctm_back.
//
//   channel   direction  word contents
//   req_bus   in         blue, green, red (8 bits each)
//   rsp_bus   out        in_range (1 bit)
//   csr_bus   in         index (3 bits), data (8 bits); always ready
//
// One pixel enters per clock while rsp_bus does not stall; rsp_bus.valid rises once the
// pixel has passed the four registered stages: max/min, reciprocal lookup, multiply,
// threshold.
// Synchronous reset clears the stage valid bits and loads the default bounds; no
// clearing pass follows, so a pixel may enter in the first cycle after reset.
// A stall on rsp_bus holds the output word; each stage behind it keeps advancing
// into empty slots, so req_bus.ready drops only once every stage holds a word.
module hsv_color_threshold_mask import hsvctm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   hsvctm_req_if.sink    req_bus,
   hsvctm_rsp_if.source  rsp_bus,
   hsvctm_csr_if.sink    csr_bus
);

   bounds_type bounds;
   logic       s2_valid;
   s2_type     s2_word;
   logic       s2_take;

   // bound registers; the user must write them only while no pixel is in flight (not enforced)
   hsvctm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .bounds  (bounds)
   );

   // V, range and raw hue, then the S and H reciprocals
   hsvctm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .s2_valid (s2_valid),
      .s2_word  (s2_word),
      .s2_take  (s2_take)
   );

   // products, rounding to 9-bit S and H, and the three range tests
   hsvctm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .s2_valid (s2_valid),
      .s2_word  (s2_word),
      .s2_take  (s2_take),
      .bounds   (bounds),
      .rsp_bus  (rsp_bus)
   );

endmodule

// File: bench/hsv_color_threshold_mask_test.sv
// Self-checking bench for hsv_color_threshold_mask: BGR pixel words in, mask bits out.
// Uses hsvctm_pkg, the hsvctm_if channel interfaces and the hsv_color_threshold_mask RTL.
// Walks a directed table, then random pixels under many threshold windows.
module hsv_color_threshold_mask_test import hsvctm_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HalfPeriod    = 5;
   localparam int ResetCycles   = 11;
   localparam int SettleCycles  = 8;      // pipeline is four stages deep
   localparam int WatchdogLimit = 2000;   // cycles with no handshake at all
   localparam int PhaseCount    = 9;
   localparam int PhaseItems    = 200;
   localparam int HoldCycles    = 64;     // long output stall to back up the pipe
   localparam int ReportLimit   = 10;

   // Threshold window as the block holds it after register writes
   typedef struct packed {
      logic [ChanW-1:0] hue_low;
      logic [ChanW-1:0] hue_high;
      logic [ChanW-1:0] sat_low;
      logic [ChanW-1:0] sat_high;
      logic [ChanW-1:0] val_low;
      logic [ChanW-1:0] val_high;
   } window_type;

   // One directed step: either a register write or a pixel word.
   // Pixel rows with known set carry a mask that is plain to see; the rest use the predictor.
   typedef struct packed {
      logic               is_write;
      logic [CsrIdxW-1:0] reg_index;
      logic [ChanW-1:0]   value;
      logic [ChanW-1:0]   blue;
      logic [ChanW-1:0]   green;
      logic [ChanW-1:0]   red;
      logic               known;
      logic               mask;
   } directed_row_type;

   localparam int DirectedRows = 39;
   localparam directed_row_type DirectedTable [DirectedRows] = '{
      // reset window passes every pixel
      '{1'b0, CsrHueLow,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1},  // black
      '{1'b0, CsrHueLow,  8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 1'b1},  // white
      '{1'b0, CsrHueLow,  8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 1'b1},  // pure red
      '{1'b0, CsrHueLow,  8'd0,   8'd0,   8'd255, 8'd0,   1'b1, 1'b1},  // pure green
      '{1'b0, CsrHueLow,  8'd0,   8'd255, 8'd0,   8'd0,   1'b1, 1'b1},  // pure blue
      '{1'b0, CsrHueLow,  8'd0,   8'd0,   8'd255, 8'd255, 1'b1, 1'b1},  // red/green tie
      '{1'b0, CsrHueLow,  8'd0,   8'd255, 8'd255, 8'd0,   1'b1, 1'b1},  // green/blue tie
      '{1'b0, CsrHueLow,  8'd0,   8'd255, 8'd0,   8'd255, 1'b1, 1'b1},  // red/blue tie
      '{1'b0, CsrHueLow,  8'd0,   8'd128, 8'd128, 8'd128, 1'b1, 1'b1},  // grey
      '{1'b0, CsrHueLow,  8'd0,   8'd1,   8'd0,   8'd0,   1'b1, 1'b1},  // dimmest blue
      // hue range wrapping through zero
      '{1'b1, CsrHueLow,  8'd170, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b1, CsrHueHigh, 8'd10,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b0, CsrHueLow,  8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 1'b0},
      '{1'b0, CsrHueLow,  8'd0,   8'd20,  8'd0,   8'd255, 1'b0, 1'b0},  // hue just below 180
      '{1'b0, CsrHueLow,  8'd0,   8'd255, 8'd0,   8'd255, 1'b0, 1'b0},
      '{1'b0, CsrHueLow,  8'd0,   8'd0,   8'd20,  8'd255, 1'b0, 1'b0},
      // wrapped with the low bound above the hue span
      '{1'b1, CsrHueLow,  8'd200, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b1, CsrHueHigh, 8'd50,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b0, CsrHueLow,  8'd0,   8'd0,   8'd255, 8'd255, 1'b0, 1'b0},
      '{1'b0, CsrHueLow,  8'd0,   8'd255, 8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b0, CsrHueLow,  8'd0,   8'd0,   8'd200, 8'd255, 1'b0, 1'b0},
      // empty saturation range
      '{1'b1, CsrHueLow,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b1, CsrHueHigh, 8'd180, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b1, CsrSatLow,  8'd200, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b1, CsrSatHigh, 8'd100, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b0, CsrHueLow,  8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 1'b0},
      '{1'b0, CsrHueLow,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b0},
      // value pinned at full scale
      '{1'b1, CsrSatLow,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b1, CsrSatHigh, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b1, CsrValLow,  8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b1, CsrValHigh, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b0, CsrHueLow,  8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 1'b1},
      '{1'b0, CsrHueLow,  8'd0,   8'd0,   8'd0,   8'd254, 1'b1, 1'b0},
      // empty value range
      '{1'b1, CsrValLow,  8'd1,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b1, CsrValHigh, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b0, CsrHueLow,  8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 1'b0},
      // saturation pinned at full scale
      '{1'b1, CsrValHigh, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b1, CsrSatLow,  8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
      '{1'b0, CsrHueLow,  8'd0,   8'd1,   8'd1,   8'd255, 1'b0, 1'b0}
   };

   // Fixed windows for the first random phases: reset window, extreme wrap,
   // everything at zero, everything at full scale.
   localparam window_type FixedWindows [4] = '{
      '{8'd0,   8'd180, 8'd0,   8'd255, 8'd0,   8'd255},
      '{8'd180, 8'd0,   8'd0,   8'd255, 8'd0,   8'd255},
      '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
      '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   hsvctm_req_if req_bus ();
   hsvctm_rsp_if rsp_bus ();
   hsvctm_csr_if csr_bus ();

   hsv_color_threshold_mask dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #HalfPeriod clock = ~clock;

   // Predictor copy of the register file and the store of pending mask bits
   window_type  active_window;
   logic        in_range_q [$];

   // Traffic shaping, set per phase by the main sequence
   bit          gaps_on;
   bit          stalls_on;
   int unsigned hold_request;
   int unsigned burst_left;

   int unsigned fail_count;
   int unsigned pixels_sent;
   int unsigned masks_set;
   int unsigned masks_clear;
   int unsigned windows_used;
   int unsigned holds_done;
   int unsigned idle_cycles;
   logic        want_bit;

   // round(num / den), zero for a zero divisor
   function automatic int nearest_quotient(input int num, input int den);
      if (den == 0) return 0;
      return (2 * num + den) / (2 * den);
   endfunction

   // floor((x + half) / 2^frac) for either sign of x
   function automatic int fixed_round(input int x);
      int unit;
      int t;
      unit = 1 << FracBits;
      t = x + int'(RoundHalf);
      if (t >= 0) return t / unit;
      return -((-t + unit - 1) / unit);
   endfunction

   // Convert the pixel to HSV and test it against the active window
   function automatic logic predict_in_range(input logic [ChanW-1:0] b, g, r);
      int bv, gv, rv, v, lo, diff, raw, hue, sat;
      int hl, hh;
      bit hue_ok, sat_ok, val_ok;
      bv = int'(b);
      gv = int'(g);
      rv = int'(r);
      v  = bv;
      lo = bv;
      if (gv > v) v = gv;
      if (rv > v) v = rv;
      if (gv < lo) lo = gv;
      if (rv < lo) lo = rv;
      diff = v - lo;
      sat = fixed_round(diff * nearest_quotient(int'(SatNum), v));
      // red wins ties over green, green over blue
      if (v == rv) raw = gv - bv;
      else if (v == gv) raw = bv - rv + 2 * diff;
      else raw = rv - gv + 4 * diff;
      hue = fixed_round(raw * nearest_quotient(int'(HueNum), diff));
      if (hue < 0) hue = hue + int'(HueSpan);
      hl = int'(active_window.hue_low);
      hh = int'(active_window.hue_high);
      if (hl <= hh) hue_ok = (hue >= hl) && (hue <= hh);
      else hue_ok = ((hue >= hl) && (hue <= int'(HueSpan))) || (hue <= hh);
      sat_ok = (sat >= int'(active_window.sat_low)) && (sat <= int'(active_window.sat_high));
      val_ok = (v >= int'(active_window.val_low)) && (v <= int'(active_window.val_high));
      return hue_ok && sat_ok && val_ok;
   endfunction

   task automatic report_failure(input string what, input logic want, input logic got);
      fail_count++;
      if (fail_count <= ReportLimit)
         $display("[%0t] %s: expected in_range %b, got %b", $realtime, what, want, got);
   endtask

   // Offer one pixel word and hold it until accepted; then maybe end the burst
   task automatic offer_pixel(input logic [ChanW-1:0] b, g, r,
                              input bit known, input logic known_mask);
      int unsigned gap;
      req_bus.valid <= 1'b1;
      req_bus.blue  <= b;
      req_bus.green <= g;
      req_bus.red   <= r;
      do @(posedge clock); while (!req_bus.ready);
      in_range_q.push_back(known ? known_mask : predict_in_range(b, g, r));
      pixels_sent++;
      if (gaps_on) begin
         if (burst_left != 0) burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   task automatic stop_pixels();
      req_bus.valid <= 1'b0;
   endtask

   // Write one bound register; valid stays up so writes can go back to back
   task automatic write_bound(input logic [CsrIdxW-1:0] idx, input logic [ChanW-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CsrHueLow:  active_window.hue_low  = value;
         CsrHueHigh: active_window.hue_high = value;
         CsrSatLow:  active_window.sat_low  = value;
         CsrSatHigh: active_window.sat_high = value;
         CsrValLow:  active_window.val_low  = value;
         CsrValHigh: active_window.val_high = value;
         default: ;
      endcase
   endtask

   task automatic finish_writes();
      csr_bus.valid <= 1'b0;
   endtask

   task automatic program_window(input window_type w);
      write_bound(CsrHueLow,  w.hue_low);
      write_bound(CsrHueHigh, w.hue_high);
      write_bound(CsrSatLow,  w.sat_low);
      write_bound(CsrSatHigh, w.sat_high);
      write_bound(CsrValLow,  w.val_low);
      write_bound(CsrValHigh, w.val_high);
      finish_writes();
      windows_used++;
   endtask

   // Hold until every expected mask bit has come back, then let the pipe settle
   task automatic wait_for_drain();
      while (in_range_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Mostly sensible windows so both mask values show up; some wrapped,
   // some with the hue low bound past the span, some empty ranges.
   function automatic window_type random_window();
      window_type w;
      int unsigned lo;
      w.hue_low = ChanW'($urandom_range(0, HueSpan));
      case ($urandom_range(0, 7))
         5: w.hue_high = ChanW'($urandom_range(0, w.hue_low));
         6: begin
            w.hue_low  = ChanW'($urandom_range(0, 255));
            w.hue_high = ChanW'($urandom_range(0, 255));
         end
         7: begin
            w.hue_low  = ChanW'($urandom_range(HueSpan + 1, 255));
            w.hue_high = ChanW'($urandom_range(0, 255));
         end
         default: w.hue_high = ChanW'($urandom_range(w.hue_low, HueSpan));
      endcase
      lo = $urandom_range(0, 160);
      w.sat_low  = ChanW'(lo);
      w.sat_high = ChanW'(($urandom_range(0, 7) == 0 && lo != 0) ? $urandom_range(0, lo - 1)
                                                                 : $urandom_range(lo, 255));
      lo = $urandom_range(0, 160);
      w.val_low  = ChanW'(lo);
      w.val_high = ChanW'(($urandom_range(0, 7) == 0 && lo != 0) ? $urandom_range(0, lo - 1)
                                                                 : $urandom_range(lo, 255));
      return w;
   endfunction

   // Pixel mix: plain random, greys, two-channel ties, channel extremes, vivid colors
   task automatic random_pixel(output logic [ChanW-1:0] b, g, r);
      logic [ChanW-1:0] x, y;
      x = ChanW'($urandom_range(0, 255));
      y = ChanW'($urandom_range(0, 255));
      b = ChanW'($urandom_range(0, 255));
      g = ChanW'($urandom_range(0, 255));
      r = ChanW'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
         0: begin
            b = x;
            g = x;
            r = x;
         end
         1: begin
            case ($urandom_range(0, 2))
               0: begin r = x; g = x; b = y; end
               1: begin g = x; b = x; r = y; end
               default: begin r = x; b = x; g = y; end
            endcase
         end
         2: begin
            b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         end
         3: begin
            case ($urandom_range(0, 2))
               0: begin r = 8'd255; b = 8'd0; end
               1: begin g = 8'd255; r = 8'd0; end
               default: begin b = 8'd255; g = 8'd0; end
            endcase
         end
         default: ;
      endcase
   endtask

   // Result side: always ready, or stall on a rotating random pattern, or hold off for a
   // long stretch when asked so the pipe fills and req_bus.ready drops.
   initial begin
      int unsigned hold_left;
      logic [15:0] pattern;
      logic [3:0]  slot;
      hold_left = 0;
      pattern   = '1;
      slot      = '0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
            holds_done++;
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (!stalls_on) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= pattern[slot];
            slot = slot + 4'd1;
            if (slot == 4'd0) begin
               // now and then a clean run with no stalls
               if ($urandom_range(0, 3) == 0) pattern = '1;
               else pattern = 16'($urandom() | $urandom());
            end
         end
      end
   end

   // Compare each accepted mask word with the oldest pending prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (in_range_q.size() == 0) begin
            report_failure("mask word with nothing pending", 1'bx, rsp_bus.in_range);
         end else begin
            want_bit = in_range_q.pop_front();
            if (rsp_bus.in_range !== want_bit) report_failure("mask mismatch", want_bit,
                                                              rsp_bus.in_range);
            else if (want_bit) masks_set++;
            else masks_clear++;
         end
      end
   end

   // Watchdog: end the run if no channel moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("Timeout: no handshake for %0d cycles, %0d mask words pending",
                     idle_cycles, in_range_q.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      bit               writing;
      directed_row_type row;
      window_type       w;
      logic [ChanW-1:0] b, g, r;

      // drive every block input to a known value before the first edge
      req_bus.valid = 1'b0;
      req_bus.blue  = '0;
      req_bus.green = '0;
      req_bus.red   = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CsrHueLow;
      csr_bus.data  = '0;
      active_window = FixedWindows[0];
      gaps_on       = 1'b1;
      stalls_on     = 1'b1;
      hold_request  = 0;
      burst_left    = 1;
      fail_count    = 0;
      pixels_sent   = 0;
      masks_set     = 0;
      masks_clear   = 0;
      windows_used  = 1;
      holds_done    = 0;
      idle_cycles   = 0;
      writing       = 1'b0;

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Directed table: drain the pipe before each group of writes, and
      // drop the write valid before the next pixel word goes out.
      for (int i = 0; i < DirectedRows; i++) begin
         row = DirectedTable[i];
         if (row.is_write) begin
            if (!writing) begin
               stop_pixels();
               wait_for_drain();
               windows_used++;
            end
            write_bound(row.reg_index, row.value);
            writing = 1'b1;
         end else begin
            if (writing) begin
               finish_writes();
               writing = 1'b0;
            end
            offer_pixel(row.blue, row.green, row.red, row.known, row.mask);
         end
      end
      stop_pixels();
      wait_for_drain();

      // Random phases, each under its own window and traffic shape
      for (int p = 0; p < PhaseCount; p++) begin
         w = (p < 4) ? FixedWindows[p] : random_window();
         program_window(w);
         gaps_on   = !(p == 0 || p == 2 || p == 5 || p == 6);
         stalls_on = !(p == 0 || p == 4);
         // back up the pipe while the sender keeps offering words
         if (p == 2 || p == 6) hold_request = HoldCycles;
         for (int n = 0; n < PhaseItems; n++) begin
            random_pixel(b, g, r);
            offer_pixel(b, g, r, 1'b0, 1'b0);
         end
         stop_pixels();
         wait_for_drain();
      end

      if (in_range_q.size() != 0) report_failure("mask words never returned", 1'bx, 1'bx);
      $display("Sent %0d pixel words under %0d threshold windows with %0d long output holds;",
               pixels_sent, windows_used, holds_done);
      $display("masks set %0d, clear %0d, failures %0d", masks_set, masks_clear, fail_count);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
